// ===== design/utf8_case_fold_alnum_filter_assert.svh =====
// assertion macros for the utf8 case fold and filter block
`ifndef UTF8_CASE_FOLD_ALNUM_FILTER_ASSERT_SVH
`define UTF8_CASE_FOLD_ALNUM_FILTER_ASSERT_SVH
`ifndef SYNTHESIS
// same-cycle implication check
`define UCF_ASSERT_IMPLY(lbl, ck, rn, ante, cons) \
  lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |-> (cons)) \
    else $error("ucf: same-cycle implication failed");
// next-cycle implication check
`define UCF_ASSERT_NEXT(lbl, ck, rn, ante, cons) \
  lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |=> (cons)) \
    else $error("ucf: next-cycle implication failed");
`else
`define UCF_ASSERT_IMPLY(lbl, ck, rn, ante, cons)
`define UCF_ASSERT_NEXT(lbl, ck, rn, ante, cons)
`endif
`endif

// ===== design/ucf_pkg.sv =====
// types, code point constants and decode/fold/encode functions
package ucf_pkg;

  typedef logic [20:0] cp_t;

  // up to four encoded bytes and their count
  typedef struct packed {
    logic [3:0][7:0] bytes;
    logic [2:0]      n;
  } enc_t;

  localparam cp_t CYR_UPPER_LO   = 21'h410;
  localparam cp_t CYR_UPPER_HI   = 21'h42F;
  localparam cp_t CASE_OFFSET    = 21'h20;
  localparam cp_t CYR_IO_UPPER   = 21'h401;
  localparam cp_t CYR_IO_LOWER   = 21'h451;
  localparam cp_t CYR_IE_LOWER   = 21'h435;
  localparam cp_t LAT_UPPER_A    = 21'h41;
  localparam cp_t LAT_UPPER_Z    = 21'h5A;
  localparam cp_t LAT_LOWER_A    = 21'h61;
  localparam cp_t LAT_LOWER_Z    = 21'h7A;
  localparam cp_t DIGIT_0        = 21'h30;
  localparam cp_t DIGIT_9        = 21'h39;
  localparam cp_t ASCII_MAX      = 21'h7F;
  localparam cp_t TWO_BYTE_MAX   = 21'h7FF;
  localparam cp_t THREE_BYTE_MAX = 21'hFFFF;

  // sequence length from the lead byte pattern, 0 for an invalid lead
  function automatic logic [2:0] lead_len(input logic [7:0] b);
    logic [2:0] l;
    if (!b[7]) begin
      l = 3'd1;
    end else if (b[7:5] == 3'b110) begin
      l = 3'd2;
    end else if (b[7:4] == 4'b1110) begin
      l = 3'd3;
    end else if (b[7:3] == 5'b11110) begin
      l = 3'd4;
    end else begin
      l = 3'd0;
    end
    return l;
  endfunction

  // gather payload bits, continuation bytes are not checked
  function automatic cp_t decode(input logic [7:0] b0, input logic [7:0] b1,
                                 input logic [7:0] b2, input logic [7:0] b3,
                                 input logic [2:0] len);
    cp_t c;
    unique case (len)
      3'd2:    c = {10'b0, b0[4:0], b1[5:0]};
      3'd3:    c = {5'b0, b0[3:0], b1[5:0], b2[5:0]};
      3'd4:    c = {b0[2:0], b1[5:0], b2[5:0], b3[5:0]};
      default: c = {13'b0, b0};
    endcase
    return c;
  endfunction

  // lowercase, optional yo fold, alnum filter and shortest-form encode
  function automatic enc_t fold_enc(input cp_t cp, input logic fold_yo);
    cp_t  c;
    logic keep;
    enc_t e;
    c = cp;
    if (c >= CYR_UPPER_LO && c <= CYR_UPPER_HI) begin
      c = c + CASE_OFFSET;
    end else if (c == CYR_IO_UPPER) begin
      c = CYR_IO_LOWER;
    end else if (c >= LAT_UPPER_A && c <= LAT_UPPER_Z) begin
      c = c + CASE_OFFSET;
    end
    if (fold_yo && c == CYR_IO_LOWER) begin
      c = CYR_IE_LOWER;
    end
    keep = (c >= DIGIT_0 && c <= DIGIT_9) || (c >= LAT_UPPER_A && c <= LAT_UPPER_Z) ||
           (c >= LAT_LOWER_A && c <= LAT_LOWER_Z) || (c > ASCII_MAX);
    e = '0;
    if (keep) begin
      if (c <= ASCII_MAX) begin
        e.bytes[0] = c[7:0];
        e.n        = 3'd1;
      end else if (c <= TWO_BYTE_MAX) begin
        e.bytes[0] = {3'b110, c[10:6]};
        e.bytes[1] = {2'b10, c[5:0]};
        e.n        = 3'd2;
      end else if (c <= THREE_BYTE_MAX) begin
        e.bytes[0] = {4'b1110, c[15:12]};
        e.bytes[1] = {2'b10, c[11:6]};
        e.bytes[2] = {2'b10, c[5:0]};
        e.n        = 3'd3;
      end else begin
        e.bytes[0] = {5'b11110, c[20:18]};
        e.bytes[1] = {2'b10, c[17:12]};
        e.bytes[2] = {2'b10, c[11:6]};
        e.bytes[3] = {2'b10, c[5:0]};
        e.n        = 3'd4;
      end
    end
    return e;
  endfunction

endpackage

// ===== design/utf8_case_fold_alnum_filter.sv =====
// streaming utf8 lowercase fold and alnum filter, one byte per beat
// a byte passes the registered input stage and then the registered output buffer before it is output
// throughput: one input beat per cycle while each byte yields at most one output byte and out_rdy
//   stays high; a byte that yields more holds the single output buffer until its last byte is taken
// reset: no open sequence, input and output stages empty, fold_yo set to 1
`include "utf8_case_fold_alnum_filter_assert.svh"

module utf8_case_fold_alnum_filter (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       cfg_vld,
  output logic       cfg_rdy,
  input  logic       cfg_fold_yo,
  input  logic       in_vld,
  output logic       in_rdy,
  input  logic [7:0] in_byte,
  input  logic       in_last,
  output logic       out_vld,
  input  logic       out_rdy,
  output logic [7:0] out_byte,
  output logic       out_valid,
  output logic       out_last
);

  logic            fold_yo_r;
  logic            stg_v_r;
  logic [7:0]      stg_byte_r;
  logic            stg_last_r;
  logic [2:0][7:0] pend_r, pend_nxt;
  logic [1:0]      cnt_r, cnt_nxt;
  logic [2:0]      seqlen_r, seqlen_nxt;
  logic [3:0][7:0] obuf_r, obuf_nxt;
  logic [3:0]      ovld_r, ovld_nxt;
  logic [2:0]      ocnt_r, ocnt_nxt;
  logic            olast_r, olast_nxt;

  logic            buf_free;
  logic            move;
  logic            take;

  logic [1:0]          cnt_eff;
  logic [7:0][7:0]     tmp;
  logic [2:0]          total;
  logic [7:0]          reach;
  logic [3:0]          dec;
  ucf_pkg::cp_t [3:0]  cp_a;
  ucf_pkg::enc_t [3:0] enc_a;
  logic [2:0]          lead_in;
  logic                complete;
  logic [3:0][7:0]     res_b;
  logic [4:0]          res_n;
  logic [2:0]          res_cnt;

  assign cfg_rdy  = 1'b1;
  assign buf_free = (ocnt_r == 3'd0) || (ocnt_r == 3'd1 && out_rdy);
  assign move     = stg_v_r && buf_free;
  assign take     = out_vld && out_rdy;
  assign in_rdy   = !stg_v_r || move;

  assign out_vld   = (ocnt_r != 3'd0);
  assign out_byte  = obuf_r[0];
  assign out_valid = ovld_r[0];
  assign out_last  = olast_r && (ocnt_r == 3'd1);

  // code points of the staged byte together with the pending sequence
  always_comb begin
    logic [2:0] lp;
    logic [4:0] pos;
    lead_in  = ucf_pkg::lead_len(stg_byte_r);
    cnt_eff  = (seqlen_r != 3'd0) ? cnt_r : 2'd0;
    complete = ((3'(cnt_r) + 3'd1) >= seqlen_r) || (cnt_r == 2'd3);
    tmp      = '0;
    for (int p = 0; p < 3; p++) begin
      if (2'(p) < cnt_eff) begin
        tmp[p] = pend_r[p];
      end
    end
    tmp[3'(cnt_eff)] = stg_byte_r;
    total = 3'(cnt_eff) + 3'd1;

    // end of string: rescan held bytes, dropping invalid leads and leads cut short
    reach = 8'b0000_0001;
    dec   = '0;
    cp_a  = '0;
    for (int p = 0; p < 4; p++) begin
      lp = ucf_pkg::lead_len(tmp[p]);
      if (reach[p] && 3'(p) < total) begin
        if (lp == 3'd0 || (3'(p) + lp) > total) begin
          reach[p + 1] = 1'b1;
        end else begin
          dec[p]              = 1'b1;
          cp_a[p]             = ucf_pkg::decode(tmp[p], tmp[p + 1], tmp[p + 2],
                                                tmp[p + 3], lp);
          reach[3'(p) + lp]   = 1'b1;
        end
      end
    end

    // mid string: at most one code point, at the head
    if (!stg_last_r) begin
      dec  = '0;
      cp_a = '0;
      if (seqlen_r == 3'd0) begin
        if (lead_in == 3'd1) begin
          dec[0]  = 1'b1;
          cp_a[0] = {13'b0, stg_byte_r};
        end
      end else if (cnt_r != 2'd0 && complete) begin
        dec[0]  = 1'b1;
        cp_a[0] = ucf_pkg::decode(tmp[0], tmp[1], tmp[2], tmp[3], 3'(cnt_r) + 3'd1);
      end
    end

    // fold, filter, encode, then pack into at most four bytes
    res_b = '0;
    res_n = '0;
    for (int p = 0; p < 4; p++) begin
      enc_a[p] = dec[p] ? ucf_pkg::fold_enc(cp_a[p], fold_yo_r) : '0;
      for (int k = 0; k < 4; k++) begin
        pos = res_n + 5'(k);
        if (3'(k) < enc_a[p].n && pos < 5'd4) begin
          res_b[pos[1:0]] = enc_a[p].bytes[k];
        end
      end
      res_n = res_n + 5'(enc_a[p].n);
    end
    res_cnt = (res_n > 5'd4) ? 3'd4 : res_n[2:0];
  end

  // sequence tracking state
  always_comb begin
    pend_nxt   = pend_r;
    cnt_nxt    = cnt_r;
    seqlen_nxt = seqlen_r;
    if (move) begin
      if (stg_last_r) begin
        cnt_nxt    = 2'd0;
        seqlen_nxt = 3'd0;
      end else if (seqlen_r == 3'd0) begin
        if (lead_in >= 3'd2) begin
          pend_nxt[0] = stg_byte_r;
          cnt_nxt     = 2'd1;
          seqlen_nxt  = lead_in;
        end
      end else if (cnt_r == 2'd0 || complete) begin
        cnt_nxt    = 2'd0;
        seqlen_nxt = 3'd0;
      end else begin
        unique case (cnt_r)
          2'd1:    pend_nxt[1] = stg_byte_r;
          default: pend_nxt[2] = stg_byte_r;
        endcase
        cnt_nxt = cnt_r + 2'd1;
      end
    end
  end

  // output buffer: load on move, shift out on each taken beat
  always_comb begin
    obuf_nxt  = obuf_r;
    ovld_nxt  = ovld_r;
    ocnt_nxt  = ocnt_r;
    olast_nxt = olast_r;
    if (move) begin
      if (stg_last_r && res_cnt == 3'd0) begin
        obuf_nxt  = '0;
        ovld_nxt  = 4'b0000;
        ocnt_nxt  = 3'd1;
        olast_nxt = 1'b1;
      end else begin
        obuf_nxt  = res_b;
        ovld_nxt  = 4'b1111;
        ocnt_nxt  = res_cnt;
        olast_nxt = stg_last_r;
      end
    end else if (take) begin
      obuf_nxt = {8'h00, obuf_r[3:1]};
      ovld_nxt = {1'b0, ovld_r[3:1]};
      ocnt_nxt = ocnt_r - 3'd1;
    end
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fold_yo_r <= 1'b1;
      stg_v_r   <= 1'b0;
      cnt_r     <= 2'd0;
      seqlen_r  <= 3'd0;
      ocnt_r    <= 3'd0;
      olast_r   <= 1'b0;
    end else begin
      if (cfg_vld && cfg_rdy) begin
        fold_yo_r <= cfg_fold_yo;
      end
      if (in_vld && in_rdy) begin
        stg_v_r <= 1'b1;
      end else if (move) begin
        stg_v_r <= 1'b0;
      end
      cnt_r    <= cnt_nxt;
      seqlen_r <= seqlen_nxt;
      ocnt_r   <= ocnt_nxt;
      olast_r  <= olast_nxt;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (in_vld && in_rdy) begin
      stg_byte_r <= in_byte;
      stg_last_r <= in_last;
    end
    pend_r <= pend_nxt;
    obuf_r <= obuf_nxt;
    ovld_r <= ovld_nxt;
  end

  // checks
  `UCF_ASSERT_IMPLY(a_no_seq_no_bytes, clk, rst_n, seqlen_r == 3'd0, cnt_r == 2'd0)
  `UCF_ASSERT_IMPLY(a_open_seq_short, clk, rst_n, seqlen_r != 3'd0, (cnt_r != 2'd0) && (3'(cnt_r) < seqlen_r))
  `UCF_ASSERT_IMPLY(a_marker_is_last, clk, rst_n, out_vld && !out_valid, out_last)
  `UCF_ASSERT_NEXT(a_last_gives_beat, clk, rst_n, move && stg_last_r, ocnt_r != 3'd0)
  `UCF_ASSERT_IMPLY(a_buf_bound, clk, rst_n, out_vld, ocnt_r <= 3'd4)

endmodule

// ===== verif/tb_top.sv =====
// testbench for the utf8 lowercase fold and alnum filter with a byte-level scoreboard
`timescale 1ns / 100ps

module tb_top;

  localparam int STALL_LIMIT = 2000;
  localparam int SETTLE_CYCLES = 6;
  localparam int HOLD_CYCLES = 300;
  localparam int PHASE_BEATS = 125;

  // predicted output stream of the filter, one entry per result beat
  class fold_scoreboard;
    typedef struct packed {
      logic [7:0] data;
      logic       valid;
      logic       last;
    } out_beat_t;

    out_beat_t  expected_q[$];
    logic [7:0] held_bytes[3];
    int         held_cnt;
    int         open_len;
    logic       fold_yo;

    function new();
      clear_held();
      fold_yo = 1'b1;
    endfunction

    function void clear_held();
      held_bytes = '{default: 8'h00};
      held_cnt = 0;
      open_len = 0;
    endfunction

    function void set_fold(logic v);
      fold_yo = v;
    endfunction

    // sequence length implied by a lead byte, 0 when it cannot start one
    static function int lead_span(logic [7:0] b);
      if (!b[7]) return 1;
      if (b[7:5] == 3'b110) return 2;
      if (b[7:4] == 4'b1110) return 3;
      if (b[7:3] == 5'b11110) return 4;
      return 0;
    endfunction

    static function int min_len(ucf_pkg::cp_t cp);
      if (cp <= ucf_pkg::ASCII_MAX) return 1;
      if (cp <= ucf_pkg::TWO_BYTE_MAX) return 2;
      if (cp <= ucf_pkg::THREE_BYTE_MAX) return 3;
      return 4;
    endfunction

    // utf8 bytes of a code point at a given length, longer than needed gives overlong
    static function void encode_len(ucf_pkg::cp_t cp, int len, ref logic [7:0] q[$]);
      case (len)
        1: q.insert(q.size(), cp[7:0]);
        2: begin
          q.insert(q.size(), {3'b110, cp[10:6]});
          q.insert(q.size(), {2'b10, cp[5:0]});
        end
        3: begin
          q.insert(q.size(), {4'b1110, cp[15:12]});
          q.insert(q.size(), {2'b10, cp[11:6]});
          q.insert(q.size(), {2'b10, cp[5:0]});
        end
        default: begin
          q.insert(q.size(), {5'b11110, cp[20:18]});
          q.insert(q.size(), {2'b10, cp[17:12]});
          q.insert(q.size(), {2'b10, cp[11:6]});
          q.insert(q.size(), {2'b10, cp[5:0]});
        end
      endcase
    endfunction

    // payload bits of a sequence, continuation markers ignored
    function ucf_pkg::cp_t join_at(logic [7:0] seq[4], int first, int len);
      case (len)
        2: return {10'b0, seq[first][4:0], seq[first+1][5:0]};
        3: return {5'b0, seq[first][3:0], seq[first+1][5:0], seq[first+2][5:0]};
        4: return {seq[first][2:0], seq[first+1][5:0], seq[first+2][5:0], seq[first+3][5:0]};
        default: return {13'b0, seq[first]};
      endcase
    endfunction

    // lowercase, yo fold, keep alnum and non-ascii, shortest re-encode
    function void fold_emit(ucf_pkg::cp_t cp, ref logic [7:0] q[$]);
      ucf_pkg::cp_t c;
      logic keep;
      c = cp;
      if (c >= ucf_pkg::CYR_UPPER_LO && c <= ucf_pkg::CYR_UPPER_HI)
        c = c + ucf_pkg::CASE_OFFSET;
      else if (c == ucf_pkg::CYR_IO_UPPER)
        c = ucf_pkg::CYR_IO_LOWER;
      else if (c >= ucf_pkg::LAT_UPPER_A && c <= ucf_pkg::LAT_UPPER_Z)
        c = c + ucf_pkg::CASE_OFFSET;
      if (fold_yo && c == ucf_pkg::CYR_IO_LOWER) c = ucf_pkg::CYR_IE_LOWER;
      keep = (c >= ucf_pkg::DIGIT_0 && c <= ucf_pkg::DIGIT_9) ||
             (c >= ucf_pkg::LAT_UPPER_A && c <= ucf_pkg::LAT_UPPER_Z) ||
             (c >= ucf_pkg::LAT_LOWER_A && c <= ucf_pkg::LAT_LOWER_Z) ||
             (c > ucf_pkg::ASCII_MAX);
      if (!keep || q.size() > 4) return;
      encode_len(c, min_len(c), q);
    endfunction

    // advance the decoder by one accepted input byte
    function void note_input(logic [7:0] b, logic last);
      logic [7:0] seq[4];
      logic [7:0] produced[$];
      out_beat_t  beat;
      int cnt, total, i, len, k;
      seq = '{default: 8'h00};
      if (last) begin
        // flush: decode what is held plus this byte, skipping leads that do not fit
        cnt = (open_len != 0) ? held_cnt : 0;
        for (k = 0; k < cnt; k++) seq[k] = held_bytes[k];
        seq[cnt] = b;
        total = cnt + 1;
        i = 0;
        while (i < total) begin
          len = lead_span(seq[i]);
          if (len == 0 || i + len > total) begin
            i++;
          end else begin
            fold_emit(join_at(seq, i, len), produced);
            i += len;
          end
        end
        clear_held();
      end else if (open_len == 0) begin
        len = lead_span(b);
        if (len == 1) begin
          fold_emit({13'b0, b}, produced);
        end else if (len >= 2) begin
          held_bytes[0] = b;
          held_cnt = 1;
          open_len = len;
        end
      end else begin
        cnt = held_cnt;
        if (cnt == 0) begin
          clear_held();
        end else if (cnt + 1 >= open_len || cnt >= 3) begin
          for (k = 0; k < cnt; k++) seq[k] = held_bytes[k];
          seq[cnt] = b;
          fold_emit(join_at(seq, 0, cnt + 1), produced);
          clear_held();
        end else begin
          held_bytes[cnt] = b;
          held_cnt = cnt + 1;
        end
      end
      if (produced.size() > 4) produced = produced[0:3];
      foreach (produced[j]) begin
        beat.data = produced[j];
        beat.valid = 1'b1;
        beat.last = last && (j == produced.size() - 1);
        expected_q.insert(expected_q.size(), beat);
      end
      // empty string end marker
      if (last && produced.size() == 0) begin
        beat.data = 8'h00;
        beat.valid = 1'b0;
        beat.last = 1'b1;
        expected_q.insert(expected_q.size(), beat);
      end
    endfunction

    // compare one result beat with the oldest prediction, empty string when it matches
    function string check_result(logic [7:0] b, logic v, logic l);
      out_beat_t want;
      if (expected_q.size() == 0)
        return $sformatf("unexpected result byte %02h valid %0b last %0b", b, v, l);
      want = expected_q.pop_front();
      if (b !== want.data || v !== want.valid || l !== want.last)
        return $sformatf("result byte %02h valid %0b last %0b, predicted %02h %0b %0b",
                         b, v, l, want.data, want.valid, want.last);
      return "";
    endfunction
  endclass

  logic       clk = 1'b0;
  logic       rst_n = 1'b0;
  logic       cfg_vld = 1'b0;
  logic       cfg_rdy;
  logic       cfg_fold_yo = 1'b1;
  logic       in_vld = 1'b0;
  logic       in_rdy;
  logic [7:0] in_byte = 8'h00;
  logic       in_last = 1'b0;
  logic       out_vld;
  logic       out_rdy = 1'b0;
  logic [7:0] out_byte;
  logic       out_valid;
  logic       out_last;

  fold_scoreboard sb;
  int errors = 0;
  int idle_pct = 0;
  int stall_pct = 0;
  int hold_left = 0;
  int phase_beats = 0;
  int stall_cycles = 0;

  utf8_case_fold_alnum_filter uut (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_vld     (cfg_vld),
    .cfg_rdy     (cfg_rdy),
    .cfg_fold_yo (cfg_fold_yo),
    .in_vld      (in_vld),
    .in_rdy      (in_rdy),
    .in_byte     (in_byte),
    .in_last     (in_last),
    .out_vld     (out_vld),
    .out_rdy     (out_rdy),
    .out_byte    (out_byte),
    .out_valid   (out_valid),
    .out_last    (out_last)
  );

  always #5 clk = ~clk;

  task automatic report_mismatch(string msg);
    errors++;
    $display("%0t: mismatch: %s", $time, msg);
  endtask

  // sample every handshake at the clock edge
  always @(posedge clk) begin : beat_monitor
    string msg;
    if (rst_n) begin
      if (out_vld && out_rdy) begin
        msg = sb.check_result(out_byte, out_valid, out_last);
        if (msg != "") report_mismatch(msg);
      end
      if (in_vld && in_rdy) sb.note_input(in_byte, in_last);
      if (cfg_vld && cfg_rdy) sb.set_fold(cfg_fold_yo);
    end
  end

  // receiver: random stalls, or a long hold-off when requested
  initial begin : out_ready
    forever begin
      @(posedge clk);
      if (hold_left > 0) begin
        hold_left--;
        out_rdy <= 1'b0;
      end else begin
        out_rdy <= ($urandom_range(99) >= stall_pct);
      end
    end
  end

  // end the run when nothing moves for too long
  initial begin : watchdog
    while (stall_cycles < STALL_LIMIT) begin
      @(posedge clk);
      if ((in_vld && in_rdy) || (out_vld && out_rdy) || (cfg_vld && cfg_rdy))
        stall_cycles = 0;
      else
        stall_cycles++;
    end
    $display("tb_top: errors");
    $finish;
  end

  task automatic send_beat(logic [7:0] b, logic last);
    while (idle_pct != 0 && $urandom_range(99) < idle_pct) begin
      in_vld <= 1'b0;
      @(posedge clk);
    end
    in_vld <= 1'b1;
    in_byte <= b;
    in_last <= last;
    do @(posedge clk); while (!in_rdy);
    phase_beats++;
  endtask

  task automatic send_string(logic [7:0] q[$]);
    foreach (q[i]) send_beat(q[i], i == q.size() - 1);
  endtask

  // stop offering and wait until every predicted beat has come out
  task automatic drain_results();
    in_vld <= 1'b0;
    @(posedge clk);
    while (sb.expected_q.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic cfg_write(logic v);
    cfg_vld <= 1'b1;
    cfg_fold_yo <= v;
    do @(posedge clk); while (!cfg_rdy);
    cfg_vld <= 1'b0;
  endtask

  function automatic ucf_pkg::cp_t pick_cp();
    int r;
    r = $urandom_range(99);
    if (r < 20) begin
      case ($urandom_range(2))
        0: return ucf_pkg::LAT_UPPER_A + ucf_pkg::cp_t'($urandom_range(25));
        1: return ucf_pkg::LAT_LOWER_A + ucf_pkg::cp_t'($urandom_range(25));
        default: return ucf_pkg::DIGIT_0 + ucf_pkg::cp_t'($urandom_range(9));
      endcase
    end
    if (r < 30) return ucf_pkg::cp_t'($urandom_range(127));
    if (r < 45) return ucf_pkg::cp_t'($urandom_range(21'h45F, 21'h400));
    if (r < 52) begin
      case ($urandom_range(2))
        0: return ucf_pkg::CYR_IO_UPPER;
        1: return ucf_pkg::CYR_IO_LOWER;
        default: return ucf_pkg::CYR_IE_LOWER;
      endcase
    end
    if (r < 65) return ucf_pkg::cp_t'($urandom_range(21'h7FF, 21'h80));
    if (r < 80) return ucf_pkg::cp_t'($urandom_range(21'hFFFF, 21'h800));
    if (r < 90) return ucf_pkg::cp_t'($urandom_range(21'h1FFFFF, 21'h10000));
    return ucf_pkg::cp_t'($urandom_range(21'hFF, 21'hC0));
  endfunction

  // mostly well-formed text with noise bytes, overlong forms, bad continuations
  // and sometimes a sequence cut off by the end of the string
  task automatic build_string(ref logic [7:0] q[$]);
    logic [7:0] one[$];
    logic [7:0] lead;
    ucf_pkg::cp_t cp;
    int n_chars, k, len, short_len, tail_len;
    q.delete();
    n_chars = ($urandom_range(99) < 5) ? $urandom_range(40, 20) : $urandom_range(10, 1);
    for (k = 0; k < n_chars; k++) begin
      if ($urandom_range(99) < 6) q.insert(q.size(), 8'($urandom));
      cp = pick_cp();
      short_len = fold_scoreboard::min_len(cp);
      len = short_len;
      if (short_len < 4 && $urandom_range(99) < 5) len = $urandom_range(4, short_len + 1);
      one.delete();
      fold_scoreboard::encode_len(cp, len, one);
      if (len > 1 && $urandom_range(99) < 4) one[$urandom_range(len - 1, 1)] = 8'($urandom);
      foreach (one[i]) q.insert(q.size(), one[i]);
    end
    if ($urandom_range(99) < 10) begin
      len = $urandom_range(4, 2);
      case (len)
        2: lead = {3'b110, 5'($urandom)};
        3: lead = {4'b1110, 4'($urandom)};
        default: lead = {5'b11110, 3'($urandom)};
      endcase
      q.insert(q.size(), lead);
      tail_len = $urandom_range(len - 2, 0);
      repeat (tail_len) q.insert(q.size(), {2'b10, 6'($urandom)});
    end
  endtask

  task automatic run_phase(int idle, int stall, logic fold, logic with_hold);
    logic [7:0] text[$];
    logic hold_done;
    hold_done = 1'b0;
    cfg_write(fold);
    idle_pct = idle;
    stall_pct = stall;
    phase_beats = 0;
    while (phase_beats < PHASE_BEATS) begin
      // long receiver hold-off while the sender keeps offering
      if (with_hold && !hold_done && phase_beats >= 20) begin
        hold_left = HOLD_CYCLES;
        hold_done = 1'b1;
      end
      build_string(text);
      send_string(text);
    end
    drain_results();
  endtask

  initial begin : stimulus
    logic [7:0] text[$];
    sb = new();
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: field extremes, filtered bytes, invalid leads, cyrillic case and yo,
    // overlong and surrogate forms, largest 4-byte form
    text = '{8'h41, 8'h7A, 8'h30, 8'h20, 8'h00, 8'hFF, 8'h80, 8'hD0, 8'h81, 8'hD0, 8'hAF,
             8'hD1, 8'h91, 8'hC1, 8'h81, 8'hED, 8'hA0, 8'h80, 8'hF7, 8'hBF, 8'hBF, 8'hBF};
    send_string(text);
    // lead cut by the end, the bytes after it decoded again
    text = '{8'hF0, 8'hC3, 8'hA9};
    send_string(text);
    // string with nothing kept
    text = '{8'h20};
    send_string(text);
    drain_results();

    run_phase(0, 0, 1'b0, 1'b1);
    run_phase(65, 0, 1'b1, 1'b0);
    run_phase(0, 65, 1'b0, 1'b0);
    run_phase(32, 32, 1'b1, 1'b0);

    if (errors == 0)
      $display("tb_top: clean");
    else
      $display("tb_top: errors");
    $finish;
  end

endmodule
